@@ sv/cubic_interpolating_resampler_assert.svh @@
// assertion macros for the cubic interpolating resampler checker
`ifndef CUBIC_INTERPOLATING_RESAMPLER_ASSERT_SVH
`define CUBIC_INTERPOLATING_RESAMPLER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CIR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("resampler check failed");

// next-cycle implication, sampled on clk, off while in reset
`define CIR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("resampler check failed");

`endif

@@ sv/cir_pkg.sv @@
// shared types and constants of the cubic interpolating resampler
`default_nettype none

package cir_pkg;

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam int MAX_OUTS     = 64;
    localparam int OUT_CNT_BITS = 7;
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_BITS   = 1;
    localparam int Q_CNT_BITS   = 2;

    typedef enum logic
    {
        CMD_SAMPLE  = 1'b0,
        CMD_RESTART = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic push;
        cmd_t cmd;
    } q_push_t;

    typedef struct packed
    {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_COEF,
        ST_MUL,
        ST_ADD,
        ST_FIN
    } back_state_t;

endpackage

`default_nettype wire

@@ sv/cubic_interpolating_resampler.sv @@
// top level of the catmull-rom cubic interpolating resampler
// input channel in_valid/in_ready carries opcode and sample_in; opcode sample
// pushes a new audio sample, opcode restart clears history, priming and phase
// output channel out_valid/out_ready carries sample_out and last; last marks
// the final output caused by one input item, an item may cause zero to 64
// configuration channel cfg_valid/cfg_ready writes step_ratio (Q4.FRAC_BITS),
// always ready, to be written only while the block is idle
// an item is accepted into a two-entry queue when it has room; the back pops
// one queued item when idle and updates history and phase in that cycle; a
// primed sample then passes through the coefficient state
// each output is made by three multiply and round-add steps of the Horner
// evaluation through one shared multiplier, then a rounding and saturation step
// a stalled receiver holds the output register; the next output waits in the
// back, and the queue keeps taking items until full
// reset, asynchronous active low, clears history, priming and the queue, sets
// phase to 1.0 and step_ratio to 1.0
`default_nettype none

module cubic_interpolating_resampler #(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          opcode,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0]      sample_out,
    output logic                               last,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [FRAC_BITS+3:0]          cfg_data
);

    localparam int RATIO_BITS = FRAC_BITS + 4;
    localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(1) << FRAC_BITS;

    logic [RATIO_BITS-1:0]  step_ratio_reg;
    logic [RATIO_BITS-1:0]  step_ratio_next;
    cir_pkg::q_push_t       q_wr;
    cir_pkg::q_head_t       q_head;
    logic [SAMPLE_BITS-1:0] q_wr_data;
    logic [SAMPLE_BITS-1:0] q_head_data;
    logic                   q_full;
    logic                   q_pop;

    assign cfg_ready       = 1'b1;
    assign step_ratio_next = cfg_valid ? cfg_data : step_ratio_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ratio_reg <= RATIO_RESET;
        end
        else
        begin
            step_ratio_reg <= step_ratio_next;
        end
    end

    cir_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .RATIO_BITS  (RATIO_BITS)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .sample_in  (sample_in),
        .step_ratio (step_ratio_reg),
        .q_full     (q_full),
        .q_wr       (q_wr),
        .q_data     (q_wr_data)
    );

    cir_queue #(
        .DATA_BITS (SAMPLE_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (q_wr),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .head_data (q_head_data)
    );

    cir_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_data  (q_head_data),
        .pop        (q_pop),
        .step_ratio (step_ratio_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .last       (last)
    );

endmodule

`default_nettype wire

@@ sv/cir_queue.sv @@
// two-entry command queue between the front and the back
`default_nettype none

module cir_queue #(
    parameter int DATA_BITS = 24
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cir_pkg::q_push_t      wr,
    input  wire logic [DATA_BITS-1:0]  wr_data,
    output logic                       full,
    input  wire logic                  pop,
    output cir_pkg::q_head_t           head,
    output logic [DATA_BITS-1:0]       head_data
);

    cir_pkg::cmd_t                 cmd_mem [cir_pkg::Q_DEPTH];
    logic [DATA_BITS-1:0]          data_mem [cir_pkg::Q_DEPTH];
    logic [cir_pkg::Q_PTR_BITS-1:0] wr_ptr_reg;
    logic [cir_pkg::Q_PTR_BITS-1:0] wr_ptr_next;
    logic [cir_pkg::Q_PTR_BITS-1:0] rd_ptr_reg;
    logic [cir_pkg::Q_PTR_BITS-1:0] rd_ptr_next;
    logic [cir_pkg::Q_CNT_BITS-1:0] cnt_reg;
    logic [cir_pkg::Q_CNT_BITS-1:0] cnt_next;
    logic                          do_push;
    logic                          do_pop;

    assign full      = (cnt_reg == cir_pkg::Q_CNT_BITS'(cir_pkg::Q_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.cmd  = cmd_mem[rd_ptr_reg];
    assign head_data = data_mem[rd_ptr_reg];

    assign do_push = wr.push && !full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cmd_mem[wr_ptr_reg]  <= wr.cmd;
            data_mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/cir_front.sv @@
// input front: accepts items, classifies them and queues commands
`default_nettype none

module cir_front #(
    parameter int SAMPLE_BITS = 24,
    parameter int RATIO_BITS  = 20
) (
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    opcode,
    input  wire logic [SAMPLE_BITS-1:0]  sample_in,
    input  wire logic [RATIO_BITS-1:0]   step_ratio,
    input  wire logic                    q_full,
    output cir_pkg::q_push_t             q_wr,
    output logic [SAMPLE_BITS-1:0]       q_data
);

    logic accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign q_data   = sample_in;

    // zero ratio: sample dropped with no effect
    always_comb
    begin
        q_wr.push = 1'b0;
        q_wr.cmd  = cir_pkg::CMD_SAMPLE;
        case (opcode)
            cir_pkg::OP_RESTART:
            begin
                q_wr.push = accept;
                q_wr.cmd  = cir_pkg::CMD_RESTART;
            end
            cir_pkg::OP_SAMPLE:
            begin
                q_wr.push = accept && (step_ratio != '0);
                q_wr.cmd  = cir_pkg::CMD_SAMPLE;
            end
            default:
            begin
                q_wr.push = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/cir_back.sv @@
// execution back: history, phase and shared-multiplier cubic evaluation
`default_nettype none

module cir_back #(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire cir_pkg::q_head_t                    head,
    input  wire logic [SAMPLE_BITS-1:0]              head_data,
    output logic                                     pop,
    input  wire logic [FRAC_BITS+3:0]                step_ratio,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]            sample_out,
    output logic                                     last
);

    localparam int PHASE_BITS = FRAC_BITS + 4;
    localparam int W          = SAMPLE_BITS + 6;
    localparam int PW         = W + FRAC_BITS + 1;

    localparam logic [PHASE_BITS-1:0] ONE_Q = PHASE_BITS'(1) << FRAC_BITS;
    localparam logic [PHASE_BITS-1:0] TWO_Q = PHASE_BITS'(2) << FRAC_BITS;
    localparam logic signed [PW-1:0]  HALF_Q = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [W-1:0]   ONE_W = W'(1);
    localparam logic signed [W-1:0]   SAT_HI = {{(W-SAMPLE_BITS+1){1'b0}},
                                                {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [W-1:0]   SAT_LO = {{(W-SAMPLE_BITS+1){1'b1}},
                                                {(SAMPLE_BITS-1){1'b0}}};

    cir_pkg::back_state_t state_reg;
    cir_pkg::back_state_t state_next;

    logic signed [SAMPLE_BITS-1:0] taps_reg [4];
    logic signed [SAMPLE_BITS-1:0] taps_next [4];
    logic [1:0]                    prime_reg;
    logic [1:0]                    prime_next;
    logic [PHASE_BITS-1:0]         phase_reg;
    logic [PHASE_BITS-1:0]         phase_next;
    logic [cir_pkg::OUT_CNT_BITS-1:0] n_reg;
    logic [cir_pkg::OUT_CNT_BITS-1:0] n_next;
    logic [1:0]                    step_reg;
    logic [1:0]                    step_next;

    logic signed [W-1:0]  a_reg, b_reg, c_reg, d_reg;
    logic signed [W-1:0]  a_next, b_next, c_next, d_next;
    logic signed [W-1:0]  p_reg, p_next;
    logic signed [PW-1:0] prod_reg, prod_next;

    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic                          out_last_reg, out_last_next;

    logic signed [W-1:0]  y0, y1, y2, y3;
    logic signed [W-1:0]  addend;
    logic signed [PW-1:0] rnd_sum;
    logic signed [PW-1:0] rnd_shift;
    logic signed [W-1:0]  r_full;
    logic signed [W-1:0]  r_sat;
    logic signed [FRAC_BITS:0] t_s;
    logic [PHASE_BITS:0]  phase_sum;
    logic [PHASE_BITS-1:0] phase_adv;
    logic                 last_now;
    logic signed [SAMPLE_BITS-1:0] s_in;

    assign out_valid  = out_valid_reg;
    assign sample_out = out_sample_reg;
    assign last       = out_last_reg;

    assign s_in = signed'(head_data);
    assign y0 = W'(taps_reg[0]);
    assign y1 = W'(taps_reg[1]);
    assign y2 = W'(taps_reg[2]);
    assign y3 = W'(taps_reg[3]);

    assign t_s = signed'({1'b0, phase_reg[FRAC_BITS-1:0]});

    always_comb
    begin
        case (step_reg)
            2'd0:    addend = b_reg;
            2'd1:    addend = a_reg;
            default: addend = d_reg;
        endcase
    end

    assign rnd_sum   = prod_reg + HALF_Q;
    assign rnd_shift = rnd_sum >>> FRAC_BITS;
    assign r_full    = (p_reg + ONE_W) >>> 1;

    always_comb
    begin
        if (r_full > SAT_HI)
        begin
            r_sat = SAT_HI;
        end
        else if (r_full < SAT_LO)
        begin
            r_sat = SAT_LO;
        end
        else
        begin
            r_sat = r_full;
        end
    end

    assign phase_sum = {1'b0, phase_reg} + {1'b0, step_ratio};
    assign phase_adv = phase_sum[PHASE_BITS] ? '1 : phase_sum[PHASE_BITS-1:0];
    assign last_now  = (phase_adv >= TWO_Q)
                    || (n_reg == cir_pkg::OUT_CNT_BITS'(cir_pkg::MAX_OUTS - 1));

    always_comb
    begin
        state_next      = state_reg;
        taps_next       = taps_reg;
        prime_next      = prime_reg;
        phase_next      = phase_reg;
        n_next          = n_reg;
        step_next       = step_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        c_next          = c_reg;
        d_next          = d_reg;
        p_next          = p_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        pop             = 1'b0;

        case (state_reg)
            cir_pkg::ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    case (head.cmd)
                        cir_pkg::CMD_RESTART:
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                taps_next[i] = '0;
                            end
                            prime_next = 2'd0;
                            phase_next = ONE_Q;
                        end
                        cir_pkg::CMD_SAMPLE:
                        begin
                            case (prime_reg)
                                2'd0:
                                begin
                                    taps_next[0] = s_in;
                                    taps_next[1] = s_in;
                                    prime_next   = 2'd1;
                                end
                                2'd1:
                                begin
                                    taps_next[2] = s_in;
                                    prime_next   = 2'd2;
                                end
                                2'd2:
                                begin
                                    taps_next[3] = s_in;
                                    prime_next   = 2'd3;
                                    phase_next   = ONE_Q;
                                    state_next   = cir_pkg::ST_COEF;
                                end
                                default:
                                begin
                                    taps_next[0] = taps_reg[1];
                                    taps_next[1] = taps_reg[2];
                                    taps_next[2] = taps_reg[3];
                                    taps_next[3] = s_in;
                                    phase_next   = (phase_reg >= TWO_Q) ? phase_reg - ONE_Q
                                                                        : ONE_Q;
                                    state_next   = cir_pkg::ST_COEF;
                                end
                            endcase
                        end
                        default:
                        begin
                            state_next = cir_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            cir_pkg::ST_COEF:
            begin
                a_next = y2 - y0;
                b_next = (y0 <<< 1) - ((y1 <<< 2) + y1) + (y2 <<< 2) - y3;
                c_next = ((y1 <<< 1) + y1) - ((y2 <<< 1) + y2) + y3 - y0;
                d_next = y1 <<< 1;
                p_next = ((y1 <<< 1) + y1) - ((y2 <<< 1) + y2) + y3 - y0;
                n_next = '0;
                step_next = 2'd0;
                if (phase_reg < TWO_Q)
                begin
                    state_next = cir_pkg::ST_MUL;
                end
                else
                begin
                    state_next = cir_pkg::ST_IDLE;
                end
            end

            cir_pkg::ST_MUL:
            begin
                prod_next  = p_reg * t_s;
                state_next = cir_pkg::ST_ADD;
            end

            cir_pkg::ST_ADD:
            begin
                p_next = W'(rnd_shift) + addend;
                if (step_reg == 2'd2)
                begin
                    state_next = cir_pkg::ST_FIN;
                end
                else
                begin
                    step_next  = step_reg + 2'd1;
                    state_next = cir_pkg::ST_MUL;
                end
            end

            cir_pkg::ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = r_sat[SAMPLE_BITS-1:0];
                    out_last_next   = last_now;
                    phase_next      = phase_adv;
                    n_next          = n_reg + 1'b1;
                    step_next       = 2'd0;
                    p_next          = c_reg;
                    state_next      = last_now ? cir_pkg::ST_IDLE : cir_pkg::ST_MUL;
                end
            end

            default:
            begin
                state_next = cir_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cir_pkg::ST_IDLE;
            prime_reg     <= 2'd0;
            phase_reg     <= ONE_Q;
            n_reg         <= '0;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                taps_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            prime_reg     <= prime_next;
            phase_reg     <= phase_next;
            n_reg         <= n_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            taps_reg      <= taps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        c_reg          <= c_next;
        d_reg          <= d_next;
        p_reg          <= p_next;
        prod_reg       <= prod_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

endmodule

`default_nettype wire

@@ sv/cir_checker.sv @@
// port-level checker for the resampler and its bind
`default_nettype none

`include "cubic_interpolating_resampler_assert.svh"

module cir_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [SAMPLE_BITS-1:0] sample_out,
    input wire logic                   last
);

    // stalled output item holds
    `CIR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_out) && $stable(last))

    // a valid output item carries known values
    `CIR_ASSERT_SAME(a_out_known, out_valid, !$isunknown(sample_out) && !$isunknown(last))

    // queue fills only through an accepted item
    `CIR_ASSERT_SAME(a_fill_by_accept, $fell(in_ready), $past(in_valid))

endmodule

bind cubic_interpolating_resampler cir_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_cir_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .last       (last)
);

`default_nettype wire
